// File: src/mfr_pkg.sv
// Package: word types, frame phase encoding and framing constants for the multidrop receiver.
`timescale 1ns / 1ps

package mfr_pkg;

  localparam logic [7:0] BCAST_ADDR   = 8'h90;
  localparam logic [7:0] ACK_OK       = 8'h80;
  localparam logic [7:0] ACK_ERR      = 8'h81;
  localparam logic [7:0] SUM_MASK     = 8'h7F;
  localparam logic [7:0] QUOTE_CHAR   = 8'h22;
  localparam logic [7:0] UNIT_ADDR_RST = 8'hF4;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QMARK  = 8'h3F;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DATA  = 2'd1,
    PH_QUOTE = 2'd2,
    PH_ARMED = 2'd3
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       tx_busy;
  } in_word_t;

  typedef struct packed {
    logic       store_valid;
    logic [7:0] store_byte;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       checksum_error;
    logic       frame_opened;
    logic       frame_is_broadcast;
  } out_word_t;

  typedef struct packed {
    logic       listening;
    phase_t     frame_phase;
    logic [7:0] running_sum;
    logic       broadcast_flag;
    logic       ack_pending;
    logic [7:0] ack_code;
  } frame_state_t;

  function automatic logic is_delim(input logic [7:0] c);
    is_delim = (c == CH_LF) || (c == CH_CR) || (c == CH_BANG) ||
               (c == CH_DOLLAR) || (c == CH_SEMI) || (c == CH_QMARK);
  endfunction

endpackage

// File: src/mfr_step.sv
// Frame decoder: next frame state and result word for one input word.
`timescale 1ns / 1ps

module mfr_step import mfr_pkg::*; (
  input  frame_state_t st,
  input  in_word_t     item,
  input  logic [7:0]   unit_address,
  output frame_state_t st_nxt,
  output out_word_t    res
);

  logic [7:0] stored;
  logic [7:0] code;
  logic       is_bcast;
  logic       sum_bad;

  assign is_bcast = (item.rx_byte == BCAST_ADDR);
  assign sum_bad  = ((st.running_sum & SUM_MASK) != item.rx_byte);
  assign code     = sum_bad ? ACK_ERR : ACK_OK;

  always_comb begin
    st_nxt = st;
    res    = '0;
    stored = item.rx_byte;
    res.frame_is_broadcast = st.broadcast_flag;
    if (!item.func) begin
      if (st.listening) begin
        if (is_bcast || item.rx_byte == unit_address) begin
          st_nxt.broadcast_flag  = is_bcast;
          st_nxt.listening       = 1'b0;
          st_nxt.frame_phase     = PH_DATA;
          st_nxt.running_sum     = '0;
          res.frame_opened       = 1'b1;
          res.frame_is_broadcast = is_bcast;
        end
      end else begin
        if (st.frame_phase == PH_ARMED) begin
          // checksum byte: replace it with the ACK code
          st_nxt.listening   = 1'b1;
          st_nxt.ack_code    = code;
          res.checksum_error = sum_bad;
          stored             = code;
          if (!st.broadcast_flag) begin
            if (item.tx_busy) begin
              st_nxt.ack_pending = 1'b1;
            end else begin
              res.send_valid = 1'b1;
              res.send_byte  = code;
            end
          end else begin
            st_nxt.broadcast_flag = 1'b0;
          end
        end else if (item.rx_byte == QUOTE_CHAR) begin
          st_nxt.frame_phase = phase_t'(st.frame_phase ^ PH_ARMED);
        end else if (st.frame_phase != PH_QUOTE && is_delim(item.rx_byte)) begin
          st_nxt.frame_phase = PH_ARMED;
        end
        res.store_valid    = 1'b1;
        res.store_byte     = stored;
        st_nxt.running_sum = st.running_sum + stored;
      end
    end else if (st.ack_pending) begin
      // transmitter done: release the held ACK
      st_nxt.ack_pending = 1'b0;
      res.send_valid     = 1'b1;
      res.send_byte      = st.ack_code;
    end
  end

endmodule

// File: src/multidrop_frame_receiver.sv
// Top level: input register, frame decoder and result register of the multidrop receiver.
// A word taken into the input register is decoded and then loaded into the result register.
// Throughput: one word per cycle while the result is not stalled; then both registers advance.
// A stalled result holds; the input register then fills once more before in_stall rises.
// Reset (rst_n low, synchronous): both registers empty, listening for an address,
// running sum and ACK state cleared, unit address back to 0xF4.
`timescale 1ns / 1ps

module multidrop_frame_receiver import mfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic         s1_valid_r;
  in_word_t     s1_data_r;
  logic         out_valid_r;
  out_word_t    out_data_r;
  frame_state_t state_r;
  frame_state_t state_nxt;
  out_word_t    res;
  logic [7:0]   unit_address_r;
  logic         out_load;
  logic         in_take;

  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  mfr_step u_step (
    .st           (state_r),
    .item         (s1_data_r),
    .unit_address (unit_address_r),
    .st_nxt       (state_nxt),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      unit_address_r <= UNIT_ADDR_RST;
      state_r        <= '{listening: 1'b1, frame_phase: PH_IDLE, running_sum: 8'h00,
                          broadcast_flag: 1'b0, ack_pending: 1'b0, ack_code: 8'h00};
    end else begin
      if (cfg_wr_en) begin
        unit_address_r <= cfg_wr_data;
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // any sent byte is an ACK code
  a_send_is_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.send_valid |->
      (out_data_r.send_byte == ACK_OK || out_data_r.send_byte == ACK_ERR))
    else $error("sent byte is not an ACK code");

  // a checksum error stores the error ACK in place of the checksum byte
  a_err_stores_nak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.checksum_error |->
      (out_data_r.store_valid && out_data_r.store_byte == ACK_ERR))
    else $error("checksum error without stored error ACK");

  // an address byte is never stored nor answered
  a_open_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.frame_opened |->
      (!out_data_r.store_valid && !out_data_r.send_valid))
    else $error("frame open word also stored or sent");

  // a held ACK is always a valid code
  a_pending_code: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.ack_pending |-> (state_r.ack_code == ACK_OK || state_r.ack_code == ACK_ERR))
    else $error("pending ACK holds a bad code");

  // the state only moves when a word passes to the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(state_r))
    else $error("frame state changed without a word");

endmodule

// File: test/multidrop_frame_receiver_test.sv
// Testbench: frame decoding, checksum ACK and address register of the multidrop receiver.
`timescale 1ns / 1ps

module multidrop_frame_receiver_test;
  import mfr_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  multidrop_frame_receiver u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  // Predicted decoder state
  logic [7:0] addr_m;
  logic       listening_m;
  phase_t     phase_m;
  logic [7:0] sum_m;
  logic       bcast_m;
  logic       ack_pend_m;
  logic [7:0] ack_code_m;

  out_word_t  store_send_q[$];
  out_word_t  want_word;
  int         mismatches = 0;
  int         words_sent = 0;
  int         stall_left = 0;
  bit         quiet = 1'b0;

  logic [7:0] delims[6] = '{CH_LF, CH_CR, CH_BANG, CH_DOLLAR, CH_SEMI, CH_QMARK};

  function automatic bit is_terminator(input logic [7:0] c);
    foreach (delims[i]) if (c == delims[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [7:0] good_sum();
    return sum_m & SUM_MASK;
  endfunction

  task automatic reset_decoder();
    addr_m      = UNIT_ADDR_RST;
    listening_m = 1'b1;
    phase_m     = PH_IDLE;
    sum_m       = 8'h00;
    bcast_m     = 1'b0;
    ack_pend_m  = 1'b0;
    ack_code_m  = 8'h00;
  endtask

  // Work out the result word of one accepted input word and queue it
  task automatic decode_rx_word(input in_word_t w);
    out_word_t  r;
    logic [7:0] c;
    r = '0;
    r.frame_is_broadcast = bcast_m;
    if (!w.func) begin
      if (listening_m) begin
        if (w.rx_byte == BCAST_ADDR || w.rx_byte == addr_m) begin
          bcast_m     = (w.rx_byte == BCAST_ADDR);
          listening_m = 1'b0;
          phase_m     = PH_DATA;
          sum_m       = 8'h00;
          r.frame_opened       = 1'b1;
          r.frame_is_broadcast = bcast_m;
        end
      end else begin
        c = w.rx_byte;
        if (phase_m == PH_ARMED) begin
          listening_m = 1'b1;
          if ((sum_m & SUM_MASK) != w.rx_byte) begin
            ack_code_m = ACK_ERR;
            r.checksum_error = 1'b1;
          end else begin
            ack_code_m = ACK_OK;
          end
          c = ack_code_m;
          if (!bcast_m) begin
            if (w.tx_busy) begin
              ack_pend_m = 1'b1;
            end else begin
              r.send_valid = 1'b1;
              r.send_byte  = ack_code_m;
            end
          end else begin
            bcast_m = 1'b0;
          end
        end else if (w.rx_byte == QUOTE_CHAR) begin
          phase_m = (phase_m == PH_QUOTE) ? PH_DATA : PH_QUOTE;
        end else if (phase_m != PH_QUOTE && is_terminator(w.rx_byte)) begin
          phase_m = PH_ARMED;
        end
        r.store_valid = 1'b1;
        r.store_byte  = c;
        sum_m = sum_m + c;
      end
    end else if (ack_pend_m) begin
      ack_pend_m   = 1'b0;
      r.send_valid = 1'b1;
      r.send_byte  = ack_code_m;
    end
    store_send_q.push_back(r);
  endtask

  task automatic send_word(input in_word_t w);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 13)) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_rx_word(w);
    words_sent++;
  endtask

  task automatic send_rx(input logic [7:0] b, input logic busy);
    in_word_t w;
    w.func    = 1'b0;
    w.rx_byte = b;
    w.tx_busy = busy;
    send_word(w);
  endtask

  task automatic send_tx_done();
    in_word_t w;
    w.func    = 1'b1;
    w.rx_byte = 8'($urandom);
    w.tx_busy = 1'($urandom);
    send_word(w);
  endtask

  // Hold input low until every predicted word has come out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (store_send_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_unit_address(input logic [7:0] a);
    drain();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = a;
    @(posedge clk);
    addr_m = a;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic send_random_frame();
    int         len;
    int         n;
    logic [7:0] b;
    if ($urandom_range(0, 4) == 0) send_tx_done();
    send_rx($urandom_range(0, 1) ? addr_m : BCAST_ADDR, 1'($urandom));
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    n = 0;
    while (n < len && !(phase_m == PH_ARMED && !listening_m)) begin
      case ($urandom_range(0, 15))
        0: b = QUOTE_CHAR;
        1: b = delims[$urandom_range(0, 5)];
        2: b = 8'($urandom_range(128, 255));
        default: b = 8'($urandom_range(0, 127));
      endcase
      if ($urandom_range(0, 15) == 3) send_tx_done();
      else send_rx(b, 1'($urandom));
      n++;
    end
    // leave one frame in ten open to break the next one
    if ($urandom_range(0, 9) != 0 && !listening_m) begin
      if (phase_m == PH_QUOTE) send_rx(QUOTE_CHAR, 1'($urandom));
      if (phase_m != PH_ARMED) send_rx(delims[$urandom_range(0, 5)], 1'($urandom));
      if ($urandom_range(0, 3) != 0) send_rx(good_sum(), 1'($urandom));
      else send_rx(8'($urandom), 1'($urandom));
    end
    if ($urandom_range(0, 1) == 0) send_tx_done();
  endtask

  task automatic run_frames(input int n);
    int target;
    target = words_sent + n;
    while (words_sent < target) send_random_frame();
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (store_send_q.size() == 0) begin
        if (mismatches < 10) $display("mismatch: result word %h with none pending", out_data);
        mismatches++;
      end else begin
        want_word = store_send_q.pop_front();
        check_field("store_valid", 8'(want_word.store_valid), 8'(out_data.store_valid));
        check_field("store_byte", want_word.store_byte, out_data.store_byte);
        check_field("send_valid", 8'(want_word.send_valid), 8'(out_data.send_valid));
        check_field("send_byte", want_word.send_byte, out_data.send_byte);
        check_field("checksum_error", 8'(want_word.checksum_error),
                    8'(out_data.checksum_error));
        check_field("frame_opened", 8'(want_word.frame_opened), 8'(out_data.frame_opened));
        check_field("frame_is_broadcast", 8'(want_word.frame_is_broadcast),
                    8'(out_data.frame_is_broadcast));
      end
    end
  end

  // Receiver side stalls in random bursts
  always @(negedge clk) begin
    if (quiet) begin
      out_stall = 1'b0;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Reset address, quoting, delimiters, pending and overwritten ACKs
  task automatic test_directed();
    send_tx_done();
    send_rx(8'h00, 1'b1);
    send_rx(UNIT_ADDR_RST, 1'b0);
    send_rx(8'hFF, 1'b0);
    send_rx(QUOTE_CHAR, 1'b1);
    send_rx(CH_SEMI, 1'b0);
    send_rx(QUOTE_CHAR, 1'b0);
    send_rx(CH_BANG, 1'b1);
    send_rx(good_sum(), 1'b1);
    send_tx_done();
    send_rx(BCAST_ADDR, 1'b0);
    send_rx(CH_QMARK, 1'b0);
    send_rx(8'hBF, 1'b0);
    send_rx(UNIT_ADDR_RST, 1'b1);
    send_rx(CH_LF, 1'b1);
    send_rx(good_sum(), 1'b0);
    send_rx(UNIT_ADDR_RST, 1'b0);
    send_rx(CH_CR, 1'b0);
    send_rx(good_sum() ^ 8'h01, 1'b1);
    send_rx(UNIT_ADDR_RST, 1'b0);
    send_rx(CH_DOLLAR, 1'b0);
    send_rx(good_sum(), 1'b1);
    send_tx_done();
    send_tx_done();
  endtask

  // Raw words, mostly ignored while listening
  task automatic test_line_noise(input int n);
    in_word_t w;
    repeat (n) begin
      w = in_word_t'(10'($urandom));
      send_word(w);
    end
  endtask

  task automatic test_address_sweep();
    logic [7:0] addrs[6];
    addrs = '{8'h00, 8'hFF, BCAST_ADDR, 8'($urandom), UNIT_ADDR_RST, 8'($urandom)};
    foreach (addrs[i]) begin
      set_unit_address(addrs[i]);
      run_frames(200);
    end
  endtask

  task automatic test_no_idle();
    set_unit_address(8'($urandom));
    quiet = 1'b1;
    run_frames(150);
  endtask

  initial begin
    reset_decoder();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_line_noise(100);
    test_address_sweep();
    test_no_idle();
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
